// ----- src/uns_pkg.sv -----
// Package for the UTF-8 name sanitizer: byte constants, byte classes and
// the queue entry type. No dependencies.
package uns_pkg;

	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0] LIMIT_RESET = 8'd63;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_END  = 8'h7F;
	localparam logic [7:0] LEAD2_LO   = 8'hC2;
	localparam logic [7:0] LEAD2_HI   = 8'hDF;
	localparam logic [7:0] LEAD3_LO   = 8'hE0;
	localparam logic [7:0] LEAD3_HI   = 8'hEF;
	localparam logic [7:0] LEAD4_LO   = 8'hF0;
	localparam logic [7:0] LEAD4_HI   = 8'hF4;
	localparam logic [7:0] CHAR_PIPE  = 8'h7C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [2:0] {
		CLS_DROP,
		CLS_PRINT,
		CLS_SPACE,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_CONT
	} byte_cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		byte_cls_t  cls;
	} item_t;

endpackage

// ----- src/uns_in_if.sv -----
// Input byte channel of the name sanitizer.
// Depends on nothing.
interface uns_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ----- src/uns_out_if.sv -----
// Result channel of the name sanitizer.
// Depends on nothing.
interface uns_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  spaces_before;
	logic [31:0] char_bytes;
	logic [2:0]  char_len;
	logic        done_res;

	modport source (output valid, output spaces_before, output char_bytes,
		output char_len, output done_res, input ready);
	modport sink (input valid, input spaces_before, input char_bytes,
		input char_len, input done_res, output ready);
endinterface

// ----- src/uns_cfg_if.sv -----
// Configuration write channel: carries the length limit.
// Depends on nothing.
interface uns_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] length_limit;

	modport source (output valid, output length_limit, input ready);
	modport sink (input valid, input length_limit, output ready);
endinterface

// ----- src/uns_front.sv -----
// Front end: takes input bytes and tags each with its byte class.
// Depends on uns_pkg and uns_in_if.
module uns_front (
	uns_in_if.sink         byte_in,
	input  logic           q_full,
	output logic           q_push,
	output uns_pkg::item_t q_item
);

	uns_pkg::byte_cls_t cls;

	always_comb begin
		logic [7:0] b;
		b = byte_in.data_byte;
		if ((b & uns_pkg::CONT_MASK) == uns_pkg::CONT_TAG) begin
			cls = uns_pkg::CLS_CONT;
		end else if (b == uns_pkg::CHAR_SPACE) begin
			cls = uns_pkg::CLS_SPACE;
		end else if (b > uns_pkg::PRINT_LO && b < uns_pkg::PRINT_END
				&& b != uns_pkg::CHAR_PIPE) begin
			cls = uns_pkg::CLS_PRINT;
		end else if (b >= uns_pkg::LEAD2_LO && b <= uns_pkg::LEAD2_HI) begin
			cls = uns_pkg::CLS_LEAD2;
		end else if (b >= uns_pkg::LEAD3_LO && b <= uns_pkg::LEAD3_HI) begin
			cls = uns_pkg::CLS_LEAD3;
		end else if (b >= uns_pkg::LEAD4_LO && b <= uns_pkg::LEAD4_HI) begin
			cls = uns_pkg::CLS_LEAD4;
		end else begin
			cls = uns_pkg::CLS_DROP;
		end
	end

	assign byte_in.ready    = !q_full;
	assign q_push           = byte_in.valid && !q_full;
	assign q_item.data_byte = byte_in.data_byte;
	assign q_item.last      = byte_in.last;
	assign q_item.cls       = cls;

endmodule

// ----- src/uns_fifo.sv -----
// Short queue of classified bytes between front and back end.
// Depends on uns_pkg.
module uns_fifo #(
	parameter int Depth = uns_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uns_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output uns_pkg::item_t head_item
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	uns_pkg::item_t mem_q [Depth];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full       = (cnt_q == CW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- src/uns_back.sv -----
// Back end: sequence assembly, length limit, space handling, result register
// and the length limit register. Depends on uns_pkg, uns_out_if, uns_cfg_if.
module uns_back (
	input  logic           clk,
	input  logic           arst_n,
	uns_cfg_if.sink        cfg,
	input  logic           head_valid,
	input  uns_pkg::item_t head_item,
	output logic           pop,
	uns_out_if.source      char_out
);

	logic [7:0]  limit_q;
	logic [23:0] seq_bytes_q;
	logic [2:0]  seq_total_q;
	logic [1:0]  seq_have_q;
	logic [7:0]  kept_q;
	logic [7:0]  held_q;
	logic        started_q;
	logic        stopped_q;

	logic        res_valid_q;
	logic [7:0]  res_spaces_q;
	logic [31:0] res_bytes_q;
	logic [2:0]  res_len_q;
	logic        res_done_q;

	logic [23:0] n_seq_bytes;
	logic [2:0]  n_seq_total;
	logic [1:0]  n_seq_have;
	logic [7:0]  n_kept;
	logic [7:0]  n_held;
	logic        n_started;
	logic        n_stopped;
	logic        n_res_valid;
	logic [7:0]  n_res_spaces;
	logic [31:0] n_res_bytes;
	logic [2:0]  n_res_len;

	assign cfg.ready = 1'b1;
	// a byte moves on when the result slot is free or being drained
	assign pop = head_valid && (!res_valid_q || char_out.ready);

	always_comb begin
		logic        do_keep;
		logic [31:0] kbytes;
		logic [2:0]  klen;
		logic [8:0]  sum;
		logic [31:0] shifted;
		logic [7:0]  b;
		logic        emit;

		b       = head_item.data_byte;
		do_keep = 1'b0;
		kbytes  = '0;
		klen    = '0;
		sum     = '0;
		emit    = 1'b0;
		shifted = {24'b0, b} << {seq_have_q, 3'b000};

		n_seq_bytes  = seq_bytes_q;
		n_seq_total  = seq_total_q;
		n_seq_have   = seq_have_q;
		n_kept       = kept_q;
		n_held       = held_q;
		n_started    = started_q;
		n_stopped    = stopped_q;
		n_res_spaces = '0;
		n_res_bytes  = '0;
		n_res_len    = '0;

		if (!stopped_q) begin
			if (seq_total_q != '0 && head_item.cls == uns_pkg::CLS_CONT) begin
				if ({1'b0, seq_have_q} + 3'd1 >= seq_total_q) begin
					do_keep     = 1'b1;
					kbytes      = {8'b0, seq_bytes_q} | shifted;
					klen        = seq_total_q;
					n_seq_total = '0;
					n_seq_have  = '0;
					n_seq_bytes = '0;
				end else begin
					n_seq_bytes = seq_bytes_q | shifted[23:0];
					n_seq_have  = seq_have_q + 2'd1;
				end
			end else begin
				// no sequence, or a broken one: look at this byte afresh
				n_seq_total = '0;
				n_seq_have  = '0;
				n_seq_bytes = '0;
				case (head_item.cls)
					uns_pkg::CLS_PRINT, uns_pkg::CLS_SPACE: begin
						do_keep = 1'b1;
						kbytes  = {24'b0, b};
						klen    = 3'd1;
					end
					uns_pkg::CLS_LEAD2: begin
						n_seq_total = 3'd2;
						n_seq_have  = 2'd1;
						n_seq_bytes = {16'b0, b};
					end
					uns_pkg::CLS_LEAD3: begin
						n_seq_total = 3'd3;
						n_seq_have  = 2'd1;
						n_seq_bytes = {16'b0, b};
					end
					uns_pkg::CLS_LEAD4: begin
						n_seq_total = 3'd4;
						n_seq_have  = 2'd1;
						n_seq_bytes = {16'b0, b};
					end
					default: begin
					end
				endcase
			end
		end

		if (do_keep) begin
			sum = {1'b0, kept_q} + {6'b0, klen};
			if (sum > {1'b0, limit_q}) begin
				n_stopped = 1'b1;
			end else begin
				n_kept = sum[7:0];
				if (klen == 3'd1 && kbytes[7:0] == uns_pkg::CHAR_SPACE) begin
					if (started_q) begin
						n_held = held_q + 8'd1;
					end
				end else begin
					emit         = 1'b1;
					n_res_spaces = held_q;
					n_res_bytes  = kbytes;
					n_res_len    = klen;
					n_held       = '0;
					n_started    = 1'b1;
				end
			end
		end

		n_res_valid = emit || head_item.last;

		if (head_item.last) begin
			n_seq_bytes = '0;
			n_seq_total = '0;
			n_seq_have  = '0;
			n_kept      = '0;
			n_held      = '0;
			n_started   = 1'b0;
			n_stopped   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= uns_pkg::LIMIT_RESET;
			seq_bytes_q <= '0;
			seq_total_q <= '0;
			seq_have_q  <= '0;
			kept_q      <= '0;
			held_q      <= '0;
			started_q   <= 1'b0;
			stopped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.length_limit;
			end
			if (pop) begin
				seq_bytes_q <= n_seq_bytes;
				seq_total_q <= n_seq_total;
				seq_have_q  <= n_seq_have;
				kept_q      <= n_kept;
				held_q      <= n_held;
				started_q   <= n_started;
				stopped_q   <= n_stopped;
				res_valid_q <= n_res_valid;
			end else if (char_out.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_spaces_q <= n_res_spaces;
			res_bytes_q  <= n_res_bytes;
			res_len_q    <= n_res_len;
			res_done_q   <= head_item.last;
		end
	end

	assign char_out.valid         = res_valid_q;
	assign char_out.spaces_before = res_spaces_q;
	assign char_out.char_bytes    = res_bytes_q;
	assign char_out.char_len      = res_len_q;
	assign char_out.done_res      = res_done_q;

endmodule

// ----- src/utf8_name_sanitizer_core.sv -----
// UTF-8 name sanitizer, top level. Uses uns_pkg, the channel interfaces,
// uns_front, uns_fifo and uns_back.
// Path: a transferred byte is written into the queue; the back end pops it and registers its result, if any.
// Throughput: one byte per cycle while the result slot is free or being drained.
// The queue of FifoDepth entries absorbs output stalls.
// Reset (arst_n low): queue empty, name state cleared, length limit back to 63.
module utf8_name_sanitizer_core #(
	parameter int FifoDepth = uns_pkg::FIFO_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	uns_in_if.sink    byte_in,
	uns_cfg_if.sink   cfg,
	uns_out_if.source char_out
);

	// Front end -> queue: one classified byte per input transfer.
	logic           q_full;
	logic           q_push;
	uns_pkg::item_t q_in_item;

	// Queue -> back end: head entry, popped when the result slot frees up.
	logic           q_valid;
	logic           q_pop;
	uns_pkg::item_t q_head;

	uns_front u_front (
		.byte_in (byte_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_in_item)
	);

	uns_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_head)
	);

	// Back end owns the name state, the limit register and the result
	// register; the result register lets the next byte proceed while the
	// current result is being taken.
	uns_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (q_valid),
		.head_item  (q_head),
		.pop        (q_pop),
		.char_out   (char_out)
	);

	// Back end never pops an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");

	// Front end never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("push into full queue");

	// An ending-only result carries no character and no spaces.
	assert property (@(posedge clk) disable iff (!arst_n)
		(char_out.valid && char_out.char_len == 3'd0) |->
			(char_out.done_res && char_out.char_bytes == 32'd0
			&& char_out.spaces_before == 8'd0))
		else $error("empty result without end mark or with payload");

	// Character length is at most four bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		char_out.valid |-> (char_out.char_len <= 3'd4))
		else $error("character length out of range");

endmodule
